FILE: rtl/rhc_pkg.sv
package rhc_pkg;

   localparam int unsigned DIVIDEND_W = 24;
   localparam int unsigned QUO_W      = 16;
   localparam int unsigned CNT_W      = 4;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);
   localparam logic [13:0] HUE_SCALE = 14'd10880;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rhc_pixel_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] saturation;
      logic [7:0]  brightness;
   } rhc_hsv_type;

   typedef struct packed {
      logic        gray;
      logic [7:0]  brightness;
      logic [7:0]  diff;
      logic [10:0] num;
   } rhc_prep_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_START,
      ST_RUN,
      ST_FINISH
   } rhc_state_type;

endpackage

FILE: rtl/rhc_prep.sv
module rhc_prep (
   input  logic                  clock,
   input  logic                  load,
   input  logic                  advance,
   input  rhc_pkg::rhc_pixel_type pixel,
   output rhc_pkg::rhc_prep_type  prep
);
   import rhc_pkg::*;

   rhc_pixel_type pixel_ff;
   rhc_prep_type  prep_ff;
   rhc_prep_type  prep_in;

   logic [7:0]  r;
   logic [7:0]  g;
   logic [7:0]  b;
   logic [7:0]  mx;
   logic [7:0]  mn;
   logic [10:0] d;

   always_comb begin
      r  = pixel_ff.red;
      g  = pixel_ff.green;
      b  = pixel_ff.blue;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d  = {3'd0, mx - mn};
      prep_in.gray       = (mx == mn);
      prep_in.brightness = mx;
      prep_in.diff       = mx - mn;
      priority if (r != mx) begin
         priority if (g == mx) begin
            priority if (b != mn) prep_in.num = 11'd3 * d - {3'd0, mx - b};
            else                  prep_in.num = d + {3'd0, mx - r};
         end else begin
            priority if (r != mn) prep_in.num = 11'd5 * d - {3'd0, mx - r};
            else                  prep_in.num = 11'd3 * d + {3'd0, mx - g};
         end
      end else begin
         priority if (g != mn) prep_in.num = d - {3'd0, mx - g};
         else                  prep_in.num = 11'd5 * d + {3'd0, mx - b};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel;
      end
      if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign prep = prep_ff;

endmodule

FILE: rtl/rhc_serial_div.sv
module rhc_serial_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rhc_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [7:0]                        divisor,
   output logic [rhc_pkg::QUO_W-1:0]         quotient,
   output logic                              done
);
   import rhc_pkg::*;

   logic [7:0]       rem_ff;
   logic [7:0]       rem_in;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W-1:0] quo_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             busy_ff;
   logic             busy_in;
   logic             done_ff;
   logic             done_in;
   logic [8:0]       trial;
   logic [8:0]       trial_sub;
   logic             fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[QUO_W-1]};
      trial_sub = trial - {1'b0, divisor};
      fits      = (trial >= {1'b0, divisor});
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      priority if (start) begin
         rem_in   = dividend[DIVIDEND_W-1:QUO_W];
         quo_in   = dividend[QUO_W-1:0];
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_sub[7:0] : trial[7:0];
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter, one pixel per beat on each side.
// req channel: req_valid/req_stall with req_data holding red, green, blue.
// rsp channel: rsp_valid/rsp_stall with rsp_data holding hue, saturation
// (both unsigned 8.8, 0..255 scale, truncated) and brightness (max channel).
// Each accepted pixel passes through sector decode, divider load, the divider
// run and result hand-off before rsp_valid rises. One pixel is in flight at
// a time; the block takes no new pixel until the last one is handed off. The
// two bit-serial dividers (hue and saturation, run side by side) retire one
// quotient bit per cycle and register their done flag; after the hand-off
// the block returns to idle to take the next pixel.
// A gray pixel returns the hue of the last colored pixel and zero saturation.
// Reset (synchronous, active high) empties the block, drops any held
// response and clears the remembered hue to zero.
// While rsp_stall is high the held response stays unchanged; the block still
// takes and converts one more pixel, then waits with req_stall high until
// the held response is taken.
module rgb_to_hsv_converter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rhc_pkg::rhc_pixel_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rhc_pkg::rhc_hsv_type   rsp_data
);
   import rhc_pkg::*;

   rhc_state_type state_ff;
   rhc_state_type state_in;

   logic load_pixel;
   logic advance;
   logic div_start;
   logic out_load;
   logic out_free;

   rhc_prep_type prep;

   logic [DIVIDEND_W-1:0] hue_dividend;
   logic [DIVIDEND_W-1:0] sat_dividend;
   logic [QUO_W-1:0]      hue_quo;
   logic [QUO_W-1:0]      sat_quo;
   logic                  hue_done;
   logic                  sat_done;

   logic [15:0]  last_hue_ff;
   logic [15:0]  last_hue_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rhc_hsv_type  rsp_data_ff;
   rhc_hsv_type  rsp_data_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_PREP;
         ST_PREP:   state_in = ST_START;
         ST_START:  state_in = ST_RUN;
         ST_RUN:    if (hue_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      load_pixel = (state_ff == ST_IDLE) && req_valid;
      advance    = (state_ff == ST_PREP);
      div_start  = (state_ff == ST_START);
      out_load   = (state_ff == ST_FINISH) && out_free;
   end

   rhc_prep u_prep (
      .clock   (clock),
      .load    (load_pixel),
      .advance (advance),
      .pixel   (req_data),
      .prep    (prep)
   );

   assign hue_dividend = {13'd0, prep.num} * {10'd0, HUE_SCALE};
   assign sat_dividend = {prep.diff, 16'd0} - {8'd0, prep.diff, 8'd0};

   rhc_serial_div u_hue_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (hue_dividend),
      .divisor  (prep.diff),
      .quotient (hue_quo),
      .done     (hue_done)
   );

   rhc_serial_div u_sat_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sat_dividend),
      .divisor  (prep.brightness),
      .quotient (sat_quo),
      .done     (sat_done)
   );

   always_comb begin
      last_hue_in  = last_hue_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.brightness = prep.brightness;
         if (prep.gray) begin
            rsp_data_in.hue        = last_hue_ff;
            rsp_data_in.saturation = '0;
         end else begin
            rsp_data_in.hue        = hue_quo;
            rsp_data_in.saturation = sat_quo;
            last_hue_in            = hue_quo;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_hue_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_hue_ff  <= last_hue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      hue_done == sat_done)
      else $error("hue and saturation dividers out of step");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      hue_done |-> state_ff == ST_RUN)
      else $error("divider finished outside the run phase");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised without a finished pixel");

   a_gray_zero_sat: assert property (@(posedge clock) disable iff (reset)
      out_load && prep.gray |=> rsp_data.saturation == '0)
      else $error("gray pixel gave nonzero saturation");

endmodule
